/* hw/rtl/pait_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indicator timer bank package
// Shared constants, codes and item types of the indicator timer bank.
// ----------------------------------------------------------------------------
package pait_pkg;

    localparam int unsigned TickRateDefault   = 1000;
    localparam int unsigned KeyPeriodDefault  = 50;
    localparam int unsigned TimerWidthDefault = 24;

    localparam int unsigned QueueDepth    = 2;
    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 3;

    localparam int unsigned EnFlash   = 0;
    localparam int unsigned EnSound   = 1;
    localparam int unsigned EnVibrate = 2;

    typedef enum logic [2:0] {
        CFG_PULSE_ENABLES    = 3'd0,
        CFG_PULSE_SOUND_TYPE = 3'd1,
        CFG_ALERT_ENABLES    = 3'd2,
        CFG_ALERT_STYLE      = 3'd3,
        CFG_DISPLAY_SLEEP    = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_PULSE    = 3'd1,
        OP_ALERT    = 3'd2,
        OP_REQUEST  = 3'd3,
        OP_TRIGGER  = 3'd4,
        OP_CANCEL   = 3'd5,
        OP_VIBRATE  = 3'd6,
        OP_SET_LED  = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        DUR_NONE     = 4'd0,
        DUR_ONE_TICK = 4'd1,
        DUR_1MS      = 4'd2,
        DUR_4MS      = 4'd3,
        DUR_15MS     = 4'd4,
        DUR_50MS     = 4'd5,
        DUR_100MS    = 4'd6,
        DUR_250MS    = 4'd7,
        DUR_500MS    = 4'd8,
        DUR_10S      = 4'd9,
        DUR_30S      = 4'd10,
        DUR_60S      = 4'd11,
        DUR_120S     = 4'd12,
        DUR_300S     = 4'd13,
        DUR_FOREVER  = 4'd14
    } dur_t;

    typedef struct packed {
        logic [2:0] operation;
        logic       alarm_level;
        logic       lock_mode;
        logic       display_enabled;
        logic       random_bit;
        logic       led_enable;
    } item_t;

    typedef struct packed {
        logic backlight_on;
        logic buzzer_on;
        logic vibrator_on;
        logic pulse_led_on;
        logic heartbeat_strobe;
        logic keyboard_strobe;
        logic backlight_active;
        logic display_awake;
        logic backlight_pending;
    } result_t;

    typedef struct packed {
        op_t  op;
        logic bl_flash;
        logic buz_set;
        logic buz_pulse;
        dur_t buz_dur;
        logic vib_set;
        dur_t vib_dur;
        logic alert_flash;
        dur_t req_dur;
        logic random_bit;
        logic led_enable;
    } cmd_t;

    typedef struct packed {
        logic buzzer_on;
        logic buzzer_running;
        logic vibrator_on;
        logic vibrator_running;
    } status_t;

endpackage

/* hw/rtl/pait_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one payload per beat from a source to a sink.
// ----------------------------------------------------------------------------
interface pait_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

/* hw/rtl/pait_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indicator timer bank front end
// Holds the configuration registers and turns each input beat into a command.
// ----------------------------------------------------------------------------
module pait_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pait_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  logic [pait_pkg::CfgDataWidth-1:0]   cfg_data,
    pait_stream_if.sink                         items,
    output logic                                cmd_valid,
    input  logic                                cmd_ready,
    output pait_pkg::cmd_t                      cmd
);
    import pait_pkg::*;

    logic [2:0] pulse_enables_reg;
    logic [1:0] pulse_sound_type_reg;
    logic [2:0] alert_enables_reg;
    logic       alert_style_reg;
    logic [2:0] display_sleep_reg;

    op_t  op;
    dur_t sound_dur;
    dur_t alert_dur;
    dur_t sleep_dur;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pulse_enables_reg    <= 3'd0;
            pulse_sound_type_reg <= 2'd0;
            alert_enables_reg    <= 3'd0;
            alert_style_reg      <= 1'b0;
            display_sleep_reg    <= 3'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PULSE_ENABLES:    pulse_enables_reg    <= cfg_data[2:0];
                CFG_PULSE_SOUND_TYPE: pulse_sound_type_reg <= cfg_data[1:0];
                CFG_ALERT_ENABLES:    alert_enables_reg    <= cfg_data[2:0];
                CFG_ALERT_STYLE:      alert_style_reg      <= cfg_data[0];
                CFG_DISPLAY_SLEEP:    display_sleep_reg    <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign op          = op_t'(items.data.operation);
    assign cmd_valid   = items.valid;
    assign items.ready = cmd_ready;

    always_comb begin
        unique case (pulse_sound_type_reg)
            2'd0:    sound_dur = DUR_1MS;
            2'd1:    sound_dur = DUR_4MS;
            default: sound_dur = DUR_15MS;
        endcase
    end

    always_comb begin
        unique case ({items.data.alarm_level, alert_style_reg})
            2'b00:   alert_dur = DUR_50MS;
            2'b01:   alert_dur = DUR_100MS;
            2'b10:   alert_dur = DUR_250MS;
            default: alert_dur = DUR_500MS;
        endcase
    end

    always_comb begin
        unique case (display_sleep_reg)
            3'd0:    sleep_dur = DUR_ONE_TICK;
            3'd1:    sleep_dur = DUR_10S;
            3'd2:    sleep_dur = DUR_30S;
            3'd3:    sleep_dur = DUR_60S;
            3'd4:    sleep_dur = DUR_120S;
            3'd5:    sleep_dur = DUR_300S;
            default: sleep_dur = DUR_FOREVER;
        endcase
    end

    always_comb begin
        cmd             = '0;
        cmd.op          = op;
        cmd.buz_dur     = DUR_NONE;
        cmd.vib_dur     = DUR_NONE;
        cmd.req_dur     = DUR_NONE;
        cmd.random_bit  = items.data.random_bit;
        cmd.led_enable  = items.data.led_enable;
        unique case (op)
            OP_PULSE: begin
                cmd.bl_flash  = pulse_enables_reg[EnFlash] && items.data.display_enabled;
                cmd.buz_set   = pulse_enables_reg[EnSound];
                cmd.buz_pulse = 1'b1;
                cmd.buz_dur   = sound_dur;
                cmd.vib_set   = pulse_enables_reg[EnVibrate];
                cmd.vib_dur   = DUR_50MS;
            end
            OP_ALERT: begin
                cmd.alert_flash = alert_enables_reg[EnFlash];
                cmd.buz_set     = alert_enables_reg[EnSound];
                cmd.buz_dur     = alert_dur;
                cmd.vib_set     = alert_enables_reg[EnVibrate];
                cmd.vib_dur     = alert_dur;
            end
            OP_REQUEST: begin
                cmd.req_dur = items.data.lock_mode ? DUR_10S : sleep_dur;
            end
            OP_VIBRATE: begin
                cmd.vib_set = 1'b1;
                cmd.vib_dur = DUR_100MS;
            end
            default: ;
        endcase
    end

endmodule

/* hw/rtl/pait_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indicator timer bank command queue
// Short first-in first-out buffer between the front end and the timer core.
// ----------------------------------------------------------------------------
module pait_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  pait_pkg::cmd_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output pait_pkg::cmd_t pop_data
);
    import pait_pkg::*;

    localparam int unsigned PtrWidth   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int unsigned CountWidth = $clog2(QueueDepth + 1);

    cmd_t                  entry_reg [QueueDepth];
    logic [PtrWidth-1:0]   wr_ptr_reg;
    logic [PtrWidth-1:0]   rd_ptr_reg;
    logic [CountWidth-1:0] count_reg;
    logic [CountWidth-1:0] count_next;
    logic                  push;
    logic                  pop;

    function automatic logic [PtrWidth-1:0] step_ptr(logic [PtrWidth-1:0] p);
        return (p == PtrWidth'(QueueDepth - 1)) ? '0 : p + PtrWidth'(1);
    endfunction

    assign push_ready = (count_reg != CountWidth'(QueueDepth));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CountWidth'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CountWidth'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= step_ptr(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= step_ptr(rd_ptr_reg);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/pait_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indicator timer bank core
// Runs the down-counters and dividers and registers one result per command.
// ----------------------------------------------------------------------------
module pait_back #(
    parameter int unsigned TICK_RATE   = pait_pkg::TickRateDefault,
    parameter int unsigned KEY_PERIOD  = pait_pkg::KeyPeriodDefault,
    parameter int unsigned TIMER_WIDTH = pait_pkg::TimerWidthDefault
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  pait_pkg::cmd_t   cmd,
    pait_stream_if.source    results,
    output pait_pkg::status_t status
);
    import pait_pkg::*;

    typedef logic [TIMER_WIDTH-1:0] timer_t;

    localparam longint unsigned TMask = (64'd1 << TIMER_WIDTH) - 64'd1;
    localparam int unsigned HbWidth  = $clog2(TICK_RATE + 1);
    localparam int unsigned KeyWidth = $clog2(KEY_PERIOD + 1);

    function automatic timer_t sat_ticks(longint unsigned v);
        return (v > TMask - 64'd1) ? timer_t'(TMask - 64'd1) : timer_t'(v);
    endfunction

    localparam timer_t Forever     = timer_t'(TMask);
    localparam timer_t Ticks1ms    = sat_ticks((64'(TICK_RATE) * 64'd1) / 64'd1000);
    localparam timer_t Ticks4ms    = sat_ticks((64'(TICK_RATE) * 64'd4) / 64'd1000);
    localparam timer_t Ticks15ms   = sat_ticks((64'(TICK_RATE) * 64'd15) / 64'd1000);
    localparam timer_t Ticks50ms   = sat_ticks((64'(TICK_RATE) * 64'd50) / 64'd1000);
    localparam timer_t Ticks100ms  = sat_ticks((64'(TICK_RATE) * 64'd100) / 64'd1000);
    localparam timer_t Ticks250ms  = sat_ticks((64'(TICK_RATE) * 64'd250) / 64'd1000);
    localparam timer_t Ticks500ms  = sat_ticks((64'(TICK_RATE) * 64'd500) / 64'd1000);
    localparam timer_t Ticks10s    = sat_ticks(64'(TICK_RATE) * 64'd10);
    localparam timer_t Ticks30s    = sat_ticks(64'(TICK_RATE) * 64'd30);
    localparam timer_t Ticks60s    = sat_ticks(64'(TICK_RATE) * 64'd60);
    localparam timer_t Ticks120s   = sat_ticks(64'(TICK_RATE) * 64'd120);
    localparam timer_t Ticks300s   = sat_ticks(64'(TICK_RATE) * 64'd300);

    function automatic timer_t dur_value(dur_t code);
        timer_t v;
        unique case (code)
            DUR_ONE_TICK: v = timer_t'(1);
            DUR_1MS:      v = Ticks1ms;
            DUR_4MS:      v = Ticks4ms;
            DUR_15MS:     v = Ticks15ms;
            DUR_50MS:     v = Ticks50ms;
            DUR_100MS:    v = Ticks100ms;
            DUR_250MS:    v = Ticks250ms;
            DUR_500MS:    v = Ticks500ms;
            DUR_10S:      v = Ticks10s;
            DUR_30S:      v = Ticks30s;
            DUR_60S:      v = Ticks60s;
            DUR_120S:     v = Ticks120s;
            DUR_300S:     v = Ticks300s;
            DUR_FOREVER:  v = Forever;
            default:      v = '0;
        endcase
        return v;
    endfunction

    timer_t bl_count_reg, bl_count_next;
    timer_t req_reg, req_next;
    logic   restart_reg, restart_next;
    logic   awake_reg, awake_next;
    timer_t buz_count_reg, buz_count_next;
    timer_t noise_count_reg, noise_count_next;
    timer_t vib_count_reg, vib_count_next;
    timer_t led_count_reg, led_count_next;
    logic   led_allowed_reg, led_allowed_next;
    logic [HbWidth-1:0]  hb_count_reg, hb_count_next;
    logic [KeyWidth-1:0] key_count_reg, key_count_next;
    logic   bl_out_reg, bl_out_next;
    logic   buz_out_reg, buz_out_next;
    logic   vib_out_reg, vib_out_next;
    logic   led_out_reg, led_out_next;
    logic   hb_strobe;
    logic   key_strobe;

    result_t result_reg, result_next;
    logic    result_valid_reg;

    logic   fire;
    timer_t bl_time;
    timer_t bl_base;
    logic   bl_take;
    timer_t buz_time;
    timer_t noise_load;
    timer_t vib_time;

    assign cmd_ready = !result_valid_reg || results.ready;
    assign fire      = cmd_valid && cmd_ready;

    assign bl_time    = (cmd.op == OP_TRIGGER) ? req_reg : Ticks50ms;
    assign bl_base    = (cmd.op == OP_TRIGGER && restart_reg) ? '0 : bl_count_reg;
    assign bl_take    = (bl_time == Forever) || (bl_base != Forever && bl_time > bl_base);
    assign buz_time   = dur_value(cmd.buz_dur) + (cmd.buz_pulse ? timer_t'(1) : timer_t'(0));
    assign noise_load = !cmd.buz_pulse ? timer_t'(1) :
                        (buz_count_reg == Forever) ? Forever : buz_count_reg + timer_t'(1);
    assign vib_time   = dur_value(cmd.vib_dur);

    always_comb begin
        bl_count_next    = bl_count_reg;
        req_next         = req_reg;
        restart_next     = restart_reg;
        awake_next       = awake_reg;
        buz_count_next   = buz_count_reg;
        noise_count_next = noise_count_reg;
        vib_count_next   = vib_count_reg;
        led_count_next   = led_count_reg;
        led_allowed_next = led_allowed_reg;
        hb_count_next    = hb_count_reg;
        key_count_next   = key_count_reg;
        bl_out_next      = bl_out_reg;
        buz_out_next     = buz_out_reg;
        vib_out_next     = vib_out_reg;
        led_out_next     = led_out_reg;
        hb_strobe        = 1'b0;
        key_strobe       = 1'b0;

        unique case (cmd.op) inside
            OP_TICK: begin
                if (hb_count_reg != '0) begin
                    hb_count_next = hb_count_reg - HbWidth'(1);
                    if (hb_count_reg == HbWidth'(1)) begin
                        hb_count_next = HbWidth'(TICK_RATE);
                        hb_strobe     = 1'b1;
                    end
                end
                if (key_count_reg != '0) begin
                    key_count_next = key_count_reg - KeyWidth'(1);
                    if (key_count_reg == KeyWidth'(1)) begin
                        key_count_next = KeyWidth'(KEY_PERIOD);
                        key_strobe     = 1'b1;
                    end
                end
                if (bl_count_reg != '0 && bl_count_reg != Forever) begin
                    bl_count_next = bl_count_reg - timer_t'(1);
                    if (bl_count_reg == timer_t'(1)) begin
                        bl_out_next = 1'b0;
                        awake_next  = 1'b0;
                    end
                end
                if (buz_count_reg != '0) begin
                    buz_count_next = buz_count_reg - timer_t'(1);
                    if (buz_count_reg == timer_t'(1)) begin
                        buz_out_next = 1'b0;
                    end else if (noise_count_reg != '0) begin
                        noise_count_next = noise_count_reg - timer_t'(1);
                        buz_out_next     = (noise_count_reg == timer_t'(1)) || cmd.random_bit;
                    end
                end
                if (vib_count_reg != '0) begin
                    vib_count_next = vib_count_reg - timer_t'(1);
                    if (vib_count_reg == timer_t'(1)) begin
                        vib_out_next = 1'b0;
                    end
                end
                if (led_count_reg != '0) begin
                    led_count_next = led_count_reg - timer_t'(1);
                    if (led_count_reg == timer_t'(1)) begin
                        led_out_next = 1'b0;
                    end
                end
            end
            OP_PULSE, OP_ALERT, OP_VIBRATE: begin
                if (cmd.bl_flash && bl_take) begin
                    if (bl_time != timer_t'(1)) begin
                        bl_out_next = 1'b1;
                    end
                    bl_count_next = bl_time;
                end
                if (cmd.alert_flash && req_reg != Forever && req_reg < Ticks500ms) begin
                    req_next = Ticks500ms;
                end
                if (cmd.buz_set && buz_time > buz_count_reg) begin
                    buz_count_next   = buz_time;
                    noise_count_next = noise_load;
                end
                if (cmd.vib_set && vib_time > vib_count_reg) begin
                    vib_out_next   = 1'b1;
                    vib_count_next = vib_time;
                end
                if (cmd.op == OP_PULSE && led_allowed_reg && Ticks50ms > led_count_reg) begin
                    led_out_next   = 1'b1;
                    led_count_next = Ticks50ms;
                end
            end
            OP_REQUEST: begin
                req_next     = dur_value(cmd.req_dur);
                restart_next = 1'b1;
                awake_next   = 1'b1;
            end
            OP_TRIGGER: begin
                bl_count_next = bl_base;
                if (bl_take) begin
                    if (bl_time != timer_t'(1)) begin
                        bl_out_next = 1'b1;
                    end
                    bl_count_next = bl_time;
                end
                req_next     = '0;
                restart_next = 1'b0;
            end
            OP_CANCEL: begin
                bl_count_next = '0;
                awake_next    = 1'b0;
                bl_out_next   = 1'b0;
            end
            default: begin
                led_count_next   = '0;
                led_allowed_next = cmd.led_enable;
            end
        endcase

        result_next.backlight_on      = bl_out_next;
        result_next.buzzer_on         = buz_out_next;
        result_next.vibrator_on       = vib_out_next;
        result_next.pulse_led_on      = led_out_next;
        result_next.heartbeat_strobe  = hb_strobe;
        result_next.keyboard_strobe   = key_strobe;
        result_next.backlight_active  = (bl_count_next != '0);
        result_next.display_awake     = awake_next;
        result_next.backlight_pending = (req_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            bl_count_reg     <= '0;
            req_reg          <= '0;
            restart_reg      <= 1'b0;
            awake_reg        <= 1'b0;
            buz_count_reg    <= '0;
            noise_count_reg  <= '0;
            vib_count_reg    <= '0;
            led_count_reg    <= '0;
            led_allowed_reg  <= 1'b0;
            hb_count_reg     <= HbWidth'(TICK_RATE);
            key_count_reg    <= KeyWidth'(KEY_PERIOD);
            bl_out_reg       <= 1'b0;
            buz_out_reg      <= 1'b0;
            vib_out_reg      <= 1'b0;
            led_out_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                bl_count_reg    <= bl_count_next;
                req_reg         <= req_next;
                restart_reg     <= restart_next;
                awake_reg       <= awake_next;
                buz_count_reg   <= buz_count_next;
                noise_count_reg <= noise_count_next;
                vib_count_reg   <= vib_count_next;
                led_count_reg   <= led_count_next;
                led_allowed_reg <= led_allowed_next;
                hb_count_reg    <= hb_count_next;
                key_count_reg   <= key_count_next;
                bl_out_reg      <= bl_out_next;
                buz_out_reg     <= buz_out_next;
                vib_out_reg     <= vib_out_next;
                led_out_reg     <= led_out_next;
            end
            if (fire) begin
                result_valid_reg <= 1'b1;
            end else if (results.ready) begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (fire) begin
            result_reg <= result_next;
        end
    end

    assign results.valid = result_valid_reg;
    assign results.data  = result_reg;

    assign status.buzzer_on        = buz_out_reg;
    assign status.buzzer_running   = (buz_count_reg != '0);
    assign status.vibrator_on      = vib_out_reg;
    assign status.vibrator_running = (vib_count_reg != '0);

endmodule

/* hw/rtl/pulse_alert_indication_timers.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse, alert and indication timer bank
// Event-driven timers for backlight, buzzer, vibrator and pulse LED, with
// heartbeat and keyboard-scan strobes.
//
// Events arrive as beats on the items stream; each accepted beat yields
// exactly one beat on the results stream holding the output levels and
// status flags after that event. The user must write configuration through
// the plain write port (cfg_we, cfg_index, cfg_data) while no event is in
// flight; the block does not enforce this. A beat into an empty pipeline is
// registered in the command queue, then in the core's result register. The
// front end decodes events into a two-entry command queue, so items stay
// ready while a finished result waits. One beat per cycle is sustained
// until results stalls; the core then holds and the queue fills, after which
// items.ready drops. Reset clears all timers, loads the heartbeat and keyboard
// dividers, turns every output off and restores the configuration defaults.
// ----------------------------------------------------------------------------
module pulse_alert_indication_timers #(
    parameter int unsigned TICK_RATE   = pait_pkg::TickRateDefault,
    parameter int unsigned KEY_PERIOD  = pait_pkg::KeyPeriodDefault,
    parameter int unsigned TIMER_WIDTH = pait_pkg::TimerWidthDefault
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pait_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  logic [pait_pkg::CfgDataWidth-1:0]   cfg_data,
    pait_stream_if.sink                         items,
    pait_stream_if.source                       results
);
    import pait_pkg::*;

    logic    front_valid;
    logic    front_ready;
    cmd_t    front_cmd;
    logic    back_valid;
    logic    back_ready;
    cmd_t    back_cmd;
    status_t status;

    pait_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (items),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    pait_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_cmd)
    );

    pait_back #(
        .TICK_RATE   (TICK_RATE),
        .KEY_PERIOD  (KEY_PERIOD),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .results   (results),
        .status    (status)
    );

`ifndef SYNTHESIS
    a_vibrator_tracks_timer: assert property (
        @(posedge clk) disable iff (!rst_n)
        status.vibrator_on == status.vibrator_running
    ) else $error("vibrator level disagrees with its timer");

    a_buzzer_needs_timer: assert property (
        @(posedge clk) disable iff (!rst_n)
        status.buzzer_on |-> status.buzzer_running
    ) else $error("buzzer on with its timer expired");

    a_empty_path_latency: assert property (
        @(posedge clk) disable iff (!rst_n)
        (items.valid && items.ready && !back_valid && (!results.valid || results.ready))
            |-> ##2 results.valid
    ) else $error("result missing two cycles after beat into empty pipeline");
`endif

endmodule
